/* rtl/shmb_pkg.sv */
// ----------------------------------------------------------------------------
// shmb_pkg
// shared types and constants of the spi host memory bridge
// ----------------------------------------------------------------------------
package shmb_pkg;

    localparam int ADDR_W = 22;
    localparam int WORD_W = 32;
    localparam int BYTE_W = 8;

    localparam logic [ADDR_W-1:0] RING_BASE_RESET = 22'h10_8000;

    // request code carried in the top two bits of the first byte
    typedef enum logic [1:0] {
        REQ_READ    = 2'b00,
        REQ_CMD     = 2'b01,
        REQ_WRITE   = 2'b10,
        REQ_INVALID = 2'b11
    } req_t;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] mosi_byte;
        logic              select_active;
    } item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] miso_byte;
        logic              word_written;
        logic [ADDR_W-1:0] written_address;
        logic [WORD_W-1:0] written_word;
    } result_t;

endpackage

/* rtl/spi_host_memory_bridge_top.sv */
// ----------------------------------------------------------------------------
// spi_host_memory_bridge_top
// spi slave front end turning host byte transactions into word memory accesses
// ----------------------------------------------------------------------------
// Each input transaction is either one spi byte or a chip select change; each
// gives exactly one result transaction. An item passes a read step that reads
// the memory word at the cursor (the memory has one read port with registered
// read data) and an execute step that merges, writes back and registers the
// result. A chip select change that flushes a partly filled word adds a second
// read step, since the missing bytes may span two memory words read one after
// the other. The next item is accepted in the cycle the current one completes,
// not before; a waiting result sits in the output register and stalls only the
// execute step. After reset the block clears the word memory, one word a cycle,
// all 2**MEM_WORD_ADDR_BITS words (65536 by default), and accepts no item
// during that pass; the ring base register may be written at any time.
// ----------------------------------------------------------------------------
module spi_host_memory_bridge_top #(
    parameter int MEM_WORD_ADDR_BITS = 16,
    parameter int CMD_RING_BYTES     = 4096
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_ready,
    input  shmb_pkg::item_t             item,
    output logic                        result_valid,
    input  logic                        result_ready,
    output shmb_pkg::result_t           result,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [shmb_pkg::ADDR_W-1:0] cfg_data
);

    localparam int AW = shmb_pkg::ADDR_W;
    localparam int WW = shmb_pkg::WORD_W;
    localparam int BW = shmb_pkg::BYTE_W;
    localparam int MW = MEM_WORD_ADDR_BITS;

    // sequencer of one item: read, optional second read, execute
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD,
        S_RD2,
        S_EX
    } ctl_t;

    // transaction phase while selected
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_NOT_IMPL,
        PH_INVALID,
        PH_READ_ADDR,
        PH_WRITE_ADDR,
        PH_READ,
        PH_WRITE
    } phase_t;

    ctl_t                ctl_reg;
    logic [MW-1:0]       clr_cnt_reg;
    shmb_pkg::item_t     item_reg;
    logic [AW-1:0]       ring_base_reg;

    // architectural state
    logic                selected_reg,   selected_next;
    phase_t              phase_reg,      phase_next;
    logic [1:0]          addr_seen_reg,  addr_seen_next;
    logic [AW-1:0]       cursor_reg,     cursor_next;
    logic [WW-1:0]       buffer_reg,     buffer_next;
    logic [1:0]          fill_reg,       fill_next;      // bytes held in buffer
    logic [AW-1:0]       wr_start_reg,   wr_start_next;

    logic                res_valid_reg;
    shmb_pkg::result_t   result_reg,     result_next;

    logic [WW-1:0]       word1_reg;      // first word of a flush
    logic [WW-1:0]       rd_data;

    logic                exec_go;
    logic                mem_rd_en;
    logic [MW-1:0]       mem_rd_addr;
    logic                mem_wr_en;
    logic [MW-1:0]       mem_wr_addr;
    logic [WW-1:0]       mem_wr_data;

    // execute step working signals
    logic                emit;
    logic [AW-1:0]       emit_addr;
    logic [WW-1:0]       emit_word;
    logic                do_wb;
    logic [WW-1:0]       wb_buf;
    logic [1:0]          wb_fill;
    logic [AW-1:0]       wb_start;
    logic [WW-1:0]       wb_merged;
    logic [1:0]          mis;
    logic [WW-1:0]       rd_word;
    logic [2:0]          byte_off;
    logic [WW-1:0]       src_word;
    logic [AW:0]         ring_end;
    logic [AW-1:0]       flush_last;

    assign cfg_ready    = 1'b1;
    assign exec_go      = (ctl_reg == S_EX) && (!res_valid_reg || result_ready);
    assign item_ready   = (ctl_reg == S_IDLE) || exec_go;
    assign result_valid = res_valid_reg;
    assign result       = result_reg;

    // ring end is compared one bit wider so that an end beyond the address
    // space never matches
    assign ring_end   = {1'b0, ring_base_reg} + (AW+1)'(CMD_RING_BYTES - 1);
    // last byte a flush has to fetch from memory
    assign flush_last = cursor_reg + {{(AW-2){1'b0}}, ~fill_reg};

    // memory read address: cursor word, then the word of the last flush byte
    assign mem_rd_en   = (ctl_reg == S_RD) || (ctl_reg == S_RD2);
    assign mem_rd_addr = (ctl_reg == S_RD2) ? flush_last[MW+1:2] : cursor_reg[MW+1:2];

    // clearing pass writes zeros, otherwise the execute step writes words
    assign mem_wr_en   = (ctl_reg == S_CLEAR) || (exec_go && emit);
    assign mem_wr_addr = (ctl_reg == S_CLEAR) ? clr_cnt_reg : emit_addr[MW+1:2];
    assign mem_wr_data = (ctl_reg == S_CLEAR) ? '0 : emit_word;

    shmb_word_mem #(
        .ADDR_BITS (MW)
    ) u_word_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (rd_data)
    );

    // execute step: one item against the state and the word just read
    always_comb
    begin
        selected_next  = selected_reg;
        phase_next     = phase_reg;
        addr_seen_next = addr_seen_reg;
        cursor_next    = cursor_reg;
        buffer_next    = buffer_reg;
        fill_next      = fill_reg;
        wr_start_next  = wr_start_reg;
        result_next    = '0;
        emit           = 1'b0;
        emit_addr      = '0;
        emit_word      = '0;
        do_wb          = 1'b0;
        wb_buf         = buffer_reg;
        wb_fill        = fill_reg;
        wb_start       = wr_start_reg;
        wb_merged      = '0;
        mis            = cursor_reg[1:0];
        rd_word        = '0;
        byte_off       = '0;
        src_word       = '0;

        if (item_reg.kind)
        begin
            // chip select change: flush a partial word, back to idle
            selected_next = item_reg.select_active;
            if (fill_reg != 2'd0)
            begin
                for (int k = 0; k < 4; k++)
                begin
                    if (2'(k) < fill_reg)
                    begin
                        emit_word[k*BW +: BW] = buffer_reg[k*BW +: BW];
                    end
                    else
                    begin
                        byte_off = {1'b0, cursor_reg[1:0]} + 3'(k) - {1'b0, fill_reg};
                        src_word = byte_off[2] ? rd_data : word1_reg;
                        emit_word[k*BW +: BW] = src_word[{byte_off[1:0], 3'b000} +: BW];
                    end
                end
                emit        = 1'b1;
                emit_addr   = cursor_reg - {{(AW-2){1'b0}}, fill_reg};
                buffer_next = '0;
                fill_next   = 2'd0;
            end
            phase_next     = PH_IDLE;
            cursor_next    = '0;
            addr_seen_next = 2'd0;
        end
        else if (selected_reg)
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    unique case (shmb_pkg::req_t'(item_reg.mosi_byte[7:6]))
                        shmb_pkg::REQ_READ:
                        begin
                            phase_next  = PH_READ_ADDR;
                            cursor_next = {{(AW-6){1'b0}}, item_reg.mosi_byte[5:0]};
                        end
                        shmb_pkg::REQ_CMD:
                        begin
                            phase_next = PH_NOT_IMPL;
                        end
                        shmb_pkg::REQ_WRITE:
                        begin
                            phase_next  = PH_WRITE_ADDR;
                            cursor_next = {{(AW-6){1'b0}}, item_reg.mosi_byte[5:0]};
                        end
                        shmb_pkg::REQ_INVALID:
                        begin
                            phase_next = PH_INVALID;
                        end
                    endcase
                end
                PH_READ_ADDR:
                begin
                    if (addr_seen_reg < 2'd2)
                    begin
                        addr_seen_next = addr_seen_reg + 2'd1;
                        cursor_next    = {cursor_reg[AW-9:0], item_reg.mosi_byte};
                    end
                    else
                    begin
                        // dummy byte: preload the tail of a misaligned word
                        phase_next  = PH_READ;
                        buffer_next = (mis != 2'd0) ? (rd_data >> {mis, 3'b000}) : '0;
                    end
                end
                PH_WRITE_ADDR:
                begin
                    if (addr_seen_reg < 2'd2)
                    begin
                        addr_seen_next = addr_seen_reg + 2'd1;
                        cursor_next    = {cursor_reg[AW-9:0], item_reg.mosi_byte};
                    end
                    else
                    begin
                        // keep the lower bytes of a word entered part way
                        phase_next    = PH_WRITE;
                        wb_buf        = rd_data & ~({WW{1'b1}} << {mis, 3'b000});
                        wb_fill       = mis;
                        wb_start      = cursor_reg;
                        wr_start_next = cursor_reg;
                        do_wb         = 1'b1;
                    end
                end
                PH_READ:
                begin
                    rd_word               = (mis == 2'd0) ? rd_data : buffer_reg;
                    result_next.miso_byte = rd_word[BW-1:0];
                    buffer_next           = rd_word >> BW;
                    cursor_next           = cursor_reg + AW'(1);
                end
                PH_WRITE:
                begin
                    do_wb = 1'b1;
                end
                default:
                begin
                end
            endcase
        end

        // byte into the write buffer, whole words go to memory
        if (do_wb)
        begin
            wb_merged = wb_buf | (WW'(item_reg.mosi_byte) << {wb_fill, 3'b000});
            if (wb_fill == 2'd3)
            begin
                emit        = 1'b1;
                emit_addr   = cursor_reg - AW'(3);
                emit_word   = wb_merged;
                buffer_next = '0;
                fill_next   = 2'd0;
            end
            else
            begin
                buffer_next = wb_merged;
                fill_next   = wb_fill + 2'd1;
            end
            if (({1'b0, cursor_reg} == ring_end) && (wb_start >= ring_base_reg))
            begin
                cursor_next = ring_base_reg;
            end
            else
            begin
                cursor_next = cursor_reg + AW'(1);
            end
        end

        if (emit)
        begin
            emit_addr[1:0]                = 2'b00;
            result_next.word_written      = 1'b1;
            result_next.written_address   = emit_addr;
            result_next.written_word      = emit_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg       <= S_CLEAR;
            clr_cnt_reg   <= '0;
            ring_base_reg <= shmb_pkg::RING_BASE_RESET;
            selected_reg  <= 1'b0;
            phase_reg     <= PH_IDLE;
            addr_seen_reg <= 2'd0;
            cursor_reg    <= '0;
            buffer_reg    <= '0;
            fill_reg      <= 2'd0;
            wr_start_reg  <= '0;
            res_valid_reg <= 1'b0;
            result_reg    <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                ring_base_reg <= cfg_data;
            end

            unique case (ctl_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + MW'(1);
                    if (&clr_cnt_reg)
                    begin
                        ctl_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (item_valid)
                    begin
                        ctl_reg <= S_RD;
                    end
                end
                S_RD:
                begin
                    if (item_reg.kind && (fill_reg != 2'd0))
                    begin
                        ctl_reg <= S_RD2;
                    end
                    else
                    begin
                        ctl_reg <= S_EX;
                    end
                end
                S_RD2:
                begin
                    ctl_reg <= S_EX;
                end
                S_EX:
                begin
                    if (exec_go)
                    begin
                        ctl_reg <= item_valid ? S_RD : S_IDLE;
                    end
                end
                default:
                begin
                    ctl_reg <= S_IDLE;
                end
            endcase

            if (exec_go)
            begin
                selected_reg  <= selected_next;
                phase_reg     <= phase_next;
                addr_seen_reg <= addr_seen_next;
                cursor_reg    <= cursor_next;
                buffer_reg    <= buffer_next;
                fill_reg      <= fill_next;
                wr_start_reg  <= wr_start_next;
                res_valid_reg <= 1'b1;
                result_reg    <= result_next;
            end
            else if (result_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
        if (ctl_reg == S_RD2)
        begin
            word1_reg <= rd_data;
        end
    end

endmodule

/* rtl/shmb_word_mem.sv */
// ----------------------------------------------------------------------------
// shmb_word_mem
// single write, single read word memory with registered read data
// ----------------------------------------------------------------------------
module shmb_word_mem #(
    parameter int ADDR_BITS = 16
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [ADDR_BITS-1:0]        wr_addr,
    input  logic [shmb_pkg::WORD_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [ADDR_BITS-1:0]        rd_addr,
    output logic [shmb_pkg::WORD_W-1:0] rd_data
);

    logic [shmb_pkg::WORD_W-1:0] mem [2**ADDR_BITS];
    logic [shmb_pkg::WORD_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* tb/tb_spi_host_memory_bridge_top.sv */
// ----------------------------------------------------------------------------
// tb_spi_host_memory_bridge_top
// self-checking testbench of the spi host memory bridge
// ----------------------------------------------------------------------------
// Drives byte and chip select transactions into the bridge and predicts each
// result with a behavioral copy of the bridge kept in this module: its own
// request state, byte cursor, word packing buffer and a full image of the word
// memory. A short directed part covers the field extremes, every request kind,
// address wrap at 22 bits, flush on a chip select change and traffic while
// deselected. A second part walks the command ring base through its extremes
// and writes across the ring end. The random part runs well-formed read and
// write transactions with random content, broken headers and noise, with
// random gaps on the input side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_spi_host_memory_bridge_top;

    localparam int ADDR_W = shmb_pkg::ADDR_W;
    localparam int WORD_W = shmb_pkg::WORD_W;
    localparam int BYTE_W = shmb_pkg::BYTE_W;

    localparam int MEM_BITS   = 16;
    localparam int MEM_WORDS  = 1 << MEM_BITS;
    localparam int RING_BYTES = 4096;
    // the clearing pass after reset writes all MEM_WORDS words with no transaction
    localparam int IDLE_LIMIT = MEM_WORDS + 40000;
    localparam int RANDOM_ITEMS = 260;
    localparam int MAX_PRINTS = 40;

    // phases of the bridge's request decoder as seen by the predictor
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_CMD,
        PH_BAD,
        PH_RD_ADDR,
        PH_WR_ADDR,
        PH_RD_DATA,
        PH_WR_DATA
    } bridge_phase_t;

    logic              clk;
    logic              rst_n;
    logic              item_valid;
    logic              item_ready;
    shmb_pkg::item_t   item;
    logic              result_valid;
    logic              result_ready;
    shmb_pkg::result_t result;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [ADDR_W-1:0] cfg_data;

    // predictor state
    logic [ADDR_W-1:0] ring_base_q;
    bit                sel_q;
    bridge_phase_t     phase_q;
    logic [1:0]        addr_seen_q;
    logic [ADDR_W-1:0] cursor_q;
    logic [WORD_W-1:0] pack_q;
    int unsigned       fill_q;
    logic [ADDR_W-1:0] wstart_q;
    logic [WORD_W-1:0] word_mem [MEM_WORDS];

    shmb_pkg::result_t pending_results[$];

    // bookkeeping
    int  mismatches;
    int  items_sent;
    int  results_seen;
    int  words_written;
    int  ring_wraps;
    int  ring_settings;
    bit  no_idle;
    bit  valid_held;

    spi_host_memory_bridge_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // word holding a byte address, memory aliased modulo its size
    function automatic logic [WORD_W-1:0] mem_word_at(logic [ADDR_W-1:0] a);
        return word_mem[a[MEM_BITS+1:2]];
    endfunction

    function automatic logic [BYTE_W-1:0] mem_byte_at(logic [ADDR_W-1:0] a);
        logic [WORD_W-1:0] w;
        w = mem_word_at(a);
        return w[{a[1:0], 3'b000} +: BYTE_W];
    endfunction

    // whole word goes to the aligned word holding the address
    function automatic void store_word(logic [ADDR_W-1:0] a, logic [WORD_W-1:0] v,
                                       inout shmb_pkg::result_t r);
        logic [ADDR_W-1:0] aligned;
        aligned = {a[ADDR_W-1:2], 2'b00};
        word_mem[aligned[MEM_BITS+1:2]] = v;
        r.word_written    = 1'b1;
        r.written_address = aligned;
        r.written_word    = v;
        words_written++;
    endfunction

    // one data byte of a write; the cursor jumps back to the ring base at the
    // ring's last byte, the end computed in 32 bits so it can lie past 22 bits
    function automatic void pack_write_byte(logic [BYTE_W-1:0] d,
                                            inout shmb_pkg::result_t r);
        int unsigned ring_end;
        ring_end = 32'(ring_base_q) + 32'(RING_BYTES - 1);
        pack_q = pack_q | ({24'b0, d} << fill_q);
        fill_q += 8;
        if (fill_q >= 32)
        begin
            store_word(cursor_q - 22'd3, pack_q, r);
            pack_q = '0;
            fill_q = 0;
        end
        if (32'(cursor_q) == ring_end && wstart_q >= ring_base_q)
        begin
            cursor_q = ring_base_q;
            ring_wraps++;
        end
        else
        begin
            cursor_q = cursor_q + 22'd1;
        end
    endfunction

    function automatic shmb_pkg::result_t predict_bridge_result(shmb_pkg::item_t it);
        shmb_pkg::result_t r;
        logic [BYTE_W-1:0] d;
        int unsigned       mis;
        r = '0;
        d = it.mosi_byte;
        // chip select change: flush a partial word from memory, back to idle
        if (it.kind)
        begin
            sel_q = it.select_active;
            if (fill_q != 0)
            begin
                while (fill_q < 32)
                begin
                    pack_q = pack_q | ({24'b0, mem_byte_at(cursor_q)} << fill_q);
                    fill_q += 8;
                    cursor_q = cursor_q + 22'd1;
                end
                store_word(cursor_q - 22'd4, pack_q, r);
                pack_q = '0;
                fill_q = 0;
            end
            phase_q     = PH_IDLE;
            cursor_q    = '0;
            addr_seen_q = '0;
            return r;
        end
        if (!sel_q)
            return r;
        case (phase_q)
            PH_IDLE:
            begin
                case (shmb_pkg::req_t'(d[7:6]))
                    shmb_pkg::REQ_READ:
                    begin
                        phase_q  = PH_RD_ADDR;
                        cursor_q = {16'b0, d[5:0]};
                    end
                    shmb_pkg::REQ_CMD:
                        phase_q = PH_CMD;
                    shmb_pkg::REQ_WRITE:
                    begin
                        phase_q  = PH_WR_ADDR;
                        cursor_q = {16'b0, d[5:0]};
                    end
                    default:
                        phase_q = PH_BAD;
                endcase
            end
            PH_RD_ADDR, PH_WR_ADDR:
            begin
                if (addr_seen_q < 2)
                begin
                    addr_seen_q++;
                    cursor_q = {cursor_q[13:0], d};
                end
                else if (phase_q == PH_RD_ADDR)
                begin
                    // dummy byte; a misaligned start preloads the upper bytes
                    mis     = 32'(cursor_q[1:0]);
                    phase_q = PH_RD_DATA;
                    pack_q  = (mis != 0) ? (mem_word_at(cursor_q) >> (8 * mis)) : '0;
                end
                else
                begin
                    // first data byte; a misaligned start keeps the lower bytes
                    mis     = 32'(cursor_q[1:0]);
                    phase_q = PH_WR_DATA;
                    fill_q  = 8 * mis;
                    pack_q  = (mis != 0) ?
                              (mem_word_at(cursor_q) & ((32'd1 << fill_q) - 32'd1)) : '0;
                    wstart_q = cursor_q;
                    pack_write_byte(d, r);
                end
            end
            PH_RD_DATA:
            begin
                if (cursor_q[1:0] == 2'b00)
                    pack_q = mem_word_at(cursor_q);
                r.miso_byte = pack_q[7:0];
                pack_q   = pack_q >> 8;
                cursor_q = cursor_q + 22'd1;
            end
            PH_WR_DATA:
                pack_write_byte(d, r);
            default:
                ;
        endcase
        return r;
    endfunction

    function automatic void reset_model();
        ring_base_q = shmb_pkg::RING_BASE_RESET;
        sel_q       = 1'b0;
        phase_q     = PH_IDLE;
        addr_seen_q = '0;
        cursor_q    = '0;
        pack_q      = '0;
        fill_q      = 0;
        wstart_q    = '0;
        for (int i = 0; i < MEM_WORDS; i++)
            word_mem[i] = '0;
    endfunction

    // ------------------------------------------------------------------------
    // driving
    // ------------------------------------------------------------------------

    // mostly back to back or short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // one input transaction; called at a rising edge, returns at the edge of
    // acceptance with valid left high so the next one can follow at once
    task automatic send_item(shmb_pkg::item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            if (valid_held)
            begin
                item_valid <= 1'b0;
                valid_held = 1'b0;
            end
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        valid_held = 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        pending_results.push_back(predict_bridge_result(it));
        items_sent++;
    endtask

    task automatic xfer(logic [BYTE_W-1:0] b);
        shmb_pkg::item_t it;
        it.kind          = 1'b0;
        it.mosi_byte     = b;
        it.select_active = 1'($urandom_range(0, 1));
        send_item(it);
    endtask

    task automatic chip_select(bit on);
        shmb_pkg::item_t it;
        it.kind          = 1'b1;
        it.mosi_byte     = 8'($urandom_range(0, 255));
        it.select_active = on;
        send_item(it);
    endtask

    task automatic header(shmb_pkg::req_t rq, logic [ADDR_W-1:0] a);
        xfer({rq, a[21:16]});
        xfer(a[15:8]);
        xfer(a[7:0]);
    endtask

    // stop sending and wait until every result has come back
    task automatic idle_drain();
        if (valid_held)
        begin
            item_valid <= 1'b0;
            valid_held = 1'b0;
        end
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // ring base written only with the bridge idle
    task automatic write_ring_base(logic [ADDR_W-1:0] v);
        idle_drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid   <= 1'b0;
        ring_base_q = v;
        ring_settings++;
    endtask

    // ------------------------------------------------------------------------
    // result side: random stalls and the checker
    // ------------------------------------------------------------------------

    initial
    begin : result_stall
        int gap;
        result_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = pick_gap();
            if (gap > 0)
            begin
                result_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    task automatic report_mismatch(string msg);
        if (mismatches < MAX_PRINTS)
            $display("MISMATCH @%0t: %s", $time, msg);
        mismatches++;
    endtask

    // compare every result transaction with the oldest prediction
    always @(posedge clk)
    begin
        shmb_pkg::result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("result transaction with nothing expected");
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.miso_byte !== want.miso_byte)
                    report_mismatch($sformatf("result %0d miso_byte %h, expected %h",
                                              results_seen, result.miso_byte,
                                              want.miso_byte));
                if (result.word_written !== want.word_written)
                    report_mismatch($sformatf("result %0d word_written %b, expected %b",
                                              results_seen, result.word_written,
                                              want.word_written));
                if (result.written_address !== want.written_address)
                    report_mismatch($sformatf("result %0d written_address %h, expected %h",
                                              results_seen, result.written_address,
                                              want.written_address));
                if (result.written_word !== want.written_word)
                    report_mismatch($sformatf("result %0d written_word %h, expected %h",
                                              results_seen, result.written_word,
                                              want.written_word));
            end
            results_seen++;
        end
    end

    // watchdog: ends the run when no channel moves for too long
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && item_ready) || (result_valid && result_ready) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // field extremes, every request kind, wrap at 22 bits, flush paths
    task automatic test_directed();
        // byte while deselected is ignored
        xfer(8'hFF);
        chip_select(1'b1);
        // write at the top of the address space, running over into address 0
        header(shmb_pkg::REQ_WRITE, 22'h3F_FFFE);
        xfer(8'h00);
        xfer(8'hFF);
        xfer(8'hA5);
        // reselect while selected flushes the partial word at address 0
        chip_select(1'b1);
        // read the same bytes back across the wrap
        header(shmb_pkg::REQ_READ, 22'h3F_FFFE);
        xfer(8'h00);
        xfer(8'h00);
        xfer(8'hFF);
        xfer(8'hFF);
        // deselect with nothing buffered
        chip_select(1'b0);
        // command request: later bytes ignored
        chip_select(1'b1);
        xfer({shmb_pkg::REQ_CMD, 6'h00});
        xfer(8'h55);
        chip_select(1'b0);
        // invalid request: later bytes ignored
        chip_select(1'b1);
        xfer({shmb_pkg::REQ_INVALID, 6'h3F});
        xfer(8'h3F);
        chip_select(1'b0);
    endtask

    // ring base through its extremes, each with a write across the ring end
    task automatic test_ring_wrap();
        logic [ADDR_W-1:0] bases [5];
        logic [ADDR_W-1:0] start;
        bases[0] = shmb_pkg::RING_BASE_RESET;
        bases[1] = '0;
        bases[2] = 22'h3F_F000;   // ring end lands exactly on the last address
        bases[3] = 22'd4194300;   // ring end lies past 22 bits, never matches
        bases[4] = 22'($urandom_range(0, 4194300));
        foreach (bases[k])
        begin
            write_ring_base(bases[k]);
            start = bases[k] + 22'd4092 - 22'($urandom_range(0, 2));
            chip_select(1'b1);
            header(shmb_pkg::REQ_WRITE, start);
            repeat (8) xfer(8'($urandom_range(0, 255)));
            chip_select(1'b0);
            // read back from the ring base, where the wrapped bytes landed
            chip_select(1'b1);
            header(shmb_pkg::REQ_READ, bases[k]);
            xfer(8'($urandom_range(0, 255)));
            repeat (4) xfer(8'($urandom_range(0, 255)));
            chip_select(1'b0);
        end
    endtask

    // addresses clustered so reads meet earlier writes, aliases and ring end
    function automatic logic [ADDR_W-1:0] pick_address();
        case ($urandom_range(0, 3))
            0:       return 22'($urandom_range(0, 255));
            1:       return 22'(32'h4_0000 * $urandom_range(0, 15) +
                                $urandom_range(0, 255));
            2:       return 22'(32'(ring_base_q) + RING_BYTES - $urandom_range(1, 12));
            default: return 22'($urandom_range(0, 22'h3F_FFFF));
        endcase
    endfunction

    task automatic test_random();
        int start_count;
        int pick;
        int last_cfg;
        start_count = items_sent;
        last_cfg    = items_sent;
        while (items_sent - start_count < RANDOM_ITEMS)
        begin
            // occasional stretch with no idling on either side
            no_idle = ($urandom_range(0, 9) == 0);
            // move the ring base between phases now and then
            if (items_sent - last_cfg > 120)
            begin
                write_ring_base(($urandom_range(0, 3) == 0) ? shmb_pkg::RING_BASE_RESET :
                                22'($urandom_range(0, 4194300)));
                last_cfg = items_sent;
            end
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                // write transaction with random length and content
                chip_select(1'b1);
                header(shmb_pkg::REQ_WRITE, pick_address());
                repeat ($urandom_range(1, 12)) xfer(8'($urandom_range(0, 255)));
                chip_select($urandom_range(0, 3) == 0);
            end
            else if (pick < 75)
            begin
                // read transaction: dummy byte then data
                chip_select(1'b1);
                header(shmb_pkg::REQ_READ, pick_address());
                repeat ($urandom_range(1, 10)) xfer(8'($urandom_range(0, 255)));
                chip_select($urandom_range(0, 3) == 0);
            end
            else if (pick < 83)
            begin
                chip_select(1'b1);
                header(($urandom_range(0, 1) == 0) ? shmb_pkg::REQ_CMD :
                       shmb_pkg::REQ_INVALID,
                       22'($urandom_range(0, 22'h3F_FFFF)));
                repeat ($urandom_range(0, 3)) xfer(8'($urandom_range(0, 255)));
                chip_select(1'b0);
            end
            else if (pick < 90)
            begin
                // broken header cut short by a select change
                chip_select(1'b1);
                repeat ($urandom_range(1, 2)) xfer(8'($urandom_range(0, 255)));
                chip_select(1'($urandom_range(0, 1)));
            end
            else
            begin
                // noise: any mix of bytes and select changes
                repeat ($urandom_range(1, 5))
                begin
                    if ($urandom_range(0, 2) == 0)
                        chip_select(1'($urandom_range(0, 1)));
                    else
                        xfer(8'($urandom_range(0, 255)));
                end
                chip_select(1'b0);
            end
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        item_valid = 1'b0;
        item       = '0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        rst_n      = 1'b0;
        no_idle    = 1'b0;
        valid_held = 1'b0;
        reset_model();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_ring_wrap();
        test_random();

        // let the last result leave and the block settle
        idle_drain();
        repeat (20) @(posedge clk);

        $display("ran %0d input transactions, %0d results compared, %0d words written",
                 items_sent, results_seen, words_written);
        $display("%0d ring base settings, %0d ring wraps, %0d mismatches",
                 ring_settings, ring_wraps, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* spi_host_memory_bridge_top.f */
rtl/shmb_pkg.sv
rtl/shmb_word_mem.sv
rtl/spi_host_memory_bridge_top.sv
tb/tb_spi_host_memory_bridge_top.sv
